/* src/gsa_pkg.sv */
`timescale 1ns / 1ps

package gsa_pkg;

    localparam int SLOT_COUNT_DEF = 64;
    localparam int GEN_WIDTH_DEF  = 16;

    localparam int HSLOT_W = 6;
    localparam int HGEN_W  = 16;

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    // request token walking down the row of slot cells
    typedef struct packed {
        logic                valid;
        logic                done;
        cmd_t                cmd;
        logic [HSLOT_W-1:0]  handle_slot;
        logic [HGEN_W-1:0]   handle_generation;
        status_t             status;
        logic [HSLOT_W-1:0]  granted_slot;
        logic [HGEN_W-1:0]   granted_generation;
    } token_t;

endpackage

/* src/gsa_if.sv */
`timescale 1ns / 1ps

interface gsa_req_if;
    import gsa_pkg::*;

    logic                valid;
    logic                ready;
    logic [0:0]          cmd;
    logic [HSLOT_W-1:0]  handle_slot;
    logic [HGEN_W-1:0]   handle_generation;

    modport source (output valid, output cmd, output handle_slot,
                    output handle_generation, input ready);
    modport sink   (input valid, input cmd, input handle_slot,
                    input handle_generation, output ready);
endinterface

interface gsa_rsp_if;
    import gsa_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [HSLOT_W-1:0]  granted_slot;
    logic [HGEN_W-1:0]   granted_generation;

    modport source (output valid, output status, output granted_slot,
                    output granted_generation, input ready);
    modport sink   (input valid, input status, input granted_slot,
                    input granted_generation, output ready);
endinterface

/* src/gsa_cell.sv */
`timescale 1ns / 1ps

module gsa_cell #(
    parameter int GEN_WIDTH = gsa_pkg::GEN_WIDTH_DEF,
    parameter int IDX       = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  gsa_pkg::token_t tok_in,
    output gsa_pkg::token_t tok_out
);
    import gsa_pkg::*;

    logic                 use_reg, use_next;
    logic [GEN_WIDTH-1:0] gen_reg, gen_next;
    token_t               tok_reg, tok_next;
    logic                 slot_hit;
    logic                 gen_hit;

    assign slot_hit = (32'(tok_in.handle_slot) == 32'(IDX));
    assign gen_hit  = (32'(gen_reg) == 32'(tok_in.handle_generation));

    always_comb
    begin
        tok_next = tok_in;
        use_next = use_reg;
        gen_next = gen_reg;
        if (tok_in.valid && !tok_in.done)
        begin
            if (tok_in.cmd == CMD_ALLOC)
            begin
                // first free cell on the way takes the request
                if (!use_reg)
                begin
                    use_next                    = 1'b1;
                    tok_next.done               = 1'b1;
                    tok_next.status             = ST_OK;
                    tok_next.granted_slot       = HSLOT_W'(IDX);
                    tok_next.granted_generation = HGEN_W'(gen_reg);
                end
            end
            else if (slot_hit)
            begin
                tok_next.done = 1'b1;
                if (use_reg && gen_hit)
                begin
                    use_next        = 1'b0;
                    gen_next        = gen_reg + GEN_WIDTH'(1);
                    tok_next.status = ST_OK;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_reg <= 1'b0;
            gen_reg <= '0;
            tok_reg <= '0;
        end
        else if (advance)
        begin
            use_reg <= use_next;
            gen_reg <= gen_next;
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* src/generational_slot_allocator_top.sv */
`timescale 1ns / 1ps
// response: the token is registered by each slot cell in turn, then by out_reg
// a new request is taken only once the last one has left the row; the token
//   steps one slot cell per cycle while the row advances; one token at a time
// a stalled response freezes the whole row until it is taken
// reset: asynchronous, all slots free, all generations zero, no request pending

module generational_slot_allocator_top #(
    parameter int SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF,
    parameter int GEN_WIDTH  = gsa_pkg::GEN_WIDTH_DEF
) (
    input logic     clk,
    input logic     rst_n,
    gsa_req_if.sink req,
    gsa_rsp_if.source rsp
);
    import gsa_pkg::*;

    token_t            chain [SLOT_COUNT+1];
    token_t            last_tok;
    logic [SLOT_COUNT:0] tok_vld;
    logic              req_fire;
    logic              advance;
    logic              leave;
    logic              busy_reg, busy_next;
    logic              out_valid_reg, out_valid_next;
    token_t            out_reg;

    assign req.ready = !busy_reg;
    assign req_fire  = req.valid && req.ready;

    always_comb
    begin
        chain[0]                    = '0;
        chain[0].valid              = req_fire;
        chain[0].cmd                = cmd_t'(req.cmd);
        chain[0].handle_slot        = req.handle_slot;
        chain[0].handle_generation  = req.handle_generation;
        chain[0].status             = (req.cmd == CMD_FREE) ? ST_INVALID : ST_FULL;
    end

    genvar gi;
    generate
        for (gi = 0; gi < SLOT_COUNT; gi++)
        begin : g_cell
            gsa_cell #(
                .GEN_WIDTH (GEN_WIDTH),
                .IDX       (gi)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .tok_in  (chain[gi]),
                .tok_out (chain[gi+1])
            );
        end
        for (gi = 0; gi <= SLOT_COUNT; gi++)
        begin : g_vld
            assign tok_vld[gi] = chain[gi].valid;
        end
    endgenerate

    assign last_tok = chain[SLOT_COUNT];
    assign advance  = !(last_tok.valid && out_valid_reg && !rsp.ready);
    assign leave    = last_tok.valid && advance;

    always_comb
    begin
        busy_next = busy_reg;
        if (req_fire)
            busy_next = 1'b1;
        else if (leave)
            busy_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (leave)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (leave)
            out_reg <= last_tok;
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.status             = out_reg.status;
    assign rsp.granted_slot       = out_reg.granted_slot;
    assign rsp.granted_generation = out_reg.granted_generation;

`ifndef SYNTH
    a_one_token : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vld))
        else $error("more than one request in the slot row");

    a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req.ready)
        else $error("request taken while another is in flight");

    a_token_busy : assert property (@(posedge clk) disable iff (!rst_n)
        last_tok.valid |-> busy_reg)
        else $error("token at end of row without a pending request");

    a_full_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |->
            (rsp.granted_slot == '0 && rsp.granted_generation == '0))
        else $error("failed request carries a grant");
`endif

endmodule
